[hw/rtl/tfb_pkg.sv]
package tfb_pkg;

  localparam int unsigned ByteW = 8;
  localparam logic [ByteW-1:0] FrameOverhead = 8'd9;

  typedef enum logic [1:0] {
    REG_START   = 2'd0,
    REG_CONTROL = 2'd1,
    REG_END     = 2'd2
  } tfb_reg_e;

  typedef enum logic [0:0] {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } tfb_op_e;

  typedef enum logic [3:0] {
    ST_FIRST,
    ST_LEN,
    ST_CTRL,
    ST_INSTR,
    ST_TAG_HI,
    ST_TAG_LO,
    ST_DLEN,
    ST_LRC,
    ST_END
  } tfb_step_e;

  typedef struct packed {
    logic        op;
    logic [7:0]  instruction;
    logic [15:0] tag;
    logic [7:0]  declared_len;
    logic [7:0]  payload_len;
    logic [7:0]  data_byte;
    logic        last_byte;
  } tfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } tfb_out_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] control_byte;
    logic [7:0] end_byte;
  } tfb_cfg_t;

  typedef struct packed {
    logic        is_payload;
    logic        close;
    logic [7:0]  instruction;
    logic [15:0] tag;
    logic [7:0]  declared_len;
    logic [7:0]  total_len;
    logic [7:0]  data_byte;
  } tfb_cmd_t;

endpackage

[hw/rtl/tfb_front.sv]
module tfb_front
  import tfb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tfb_in_t  in_word_i,
  input  logic     q_full_i,
  output logic     push_o,
  output tfb_cmd_t push_cmd_o
);

  logic open_q, open_d;
  logic accept;
  logic is_payload;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_payload = (in_word_i.op == OP_PAYLOAD);

  always_comb begin
    open_d = open_q;
    push_o = 1'b0;
    if (accept) begin
      if (!is_payload) begin
        push_o = 1'b1;
        open_d = (in_word_i.payload_len != '0);
      end else if (open_q) begin
        push_o = 1'b1;
        open_d = !in_word_i.last_byte;
      end
    end
  end

  always_comb begin
    push_cmd_o.is_payload   = is_payload;
    push_cmd_o.close        = is_payload ? in_word_i.last_byte
                                         : (in_word_i.payload_len == '0);
    push_cmd_o.instruction  = in_word_i.instruction;
    push_cmd_o.tag          = in_word_i.tag;
    push_cmd_o.declared_len = in_word_i.declared_len;
    push_cmd_o.total_len    = in_word_i.payload_len + FrameOverhead;
    push_cmd_o.data_byte    = in_word_i.data_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else begin
      open_q <= open_d;
    end
  end

endmodule

[hw/rtl/tfb_queue.sv]
module tfb_queue
  import tfb_pkg::*;
#(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  tfb_cmd_t push_cmd_i,
  output logic     full_o,
  output logic     head_valid_o,
  output tfb_cmd_t head_cmd_o,
  input  logic     pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  tfb_cmd_t          mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (cnt_q == CntW'(Depth));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/tfb_back.sv]
module tfb_back
  import tfb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tfb_cfg_t cfg_i,
  input  logic     head_valid_i,
  input  tfb_cmd_t head_cmd_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tfb_out_t out_word_o
);

  tfb_step_e  step_q, step_d;
  logic [7:0] lrc_q, lrc_d;
  logic       out_valid_q;
  tfb_out_t   out_q;
  logic       can_emit, emit, final_step;
  logic [7:0] cur_byte;

  assign can_emit    = !out_valid_q || out_ready_i;
  assign emit        = head_valid_i && can_emit;
  assign pop_o       = emit && final_step;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // next step
  always_comb begin
    step_d = step_q;
    if (emit) begin
      if (final_step) begin
        step_d = ST_FIRST;
      end else begin
        case (step_q)
          ST_FIRST:  step_d = head_cmd_i.is_payload ? ST_LRC : ST_LEN;
          ST_LEN:    step_d = ST_CTRL;
          ST_CTRL:   step_d = ST_INSTR;
          ST_INSTR:  step_d = ST_TAG_HI;
          ST_TAG_HI: step_d = ST_TAG_LO;
          ST_TAG_LO: step_d = ST_DLEN;
          ST_DLEN:   step_d = ST_LRC;
          ST_LRC:    step_d = ST_END;
          default:   step_d = ST_FIRST;
        endcase
      end
    end
  end

  // byte selection and running check byte
  always_comb begin
    final_step = 1'b0;
    cur_byte   = '0;
    case (step_q)
      ST_FIRST: begin
        cur_byte   = head_cmd_i.is_payload ? head_cmd_i.data_byte : cfg_i.start_byte;
        final_step = head_cmd_i.is_payload && !head_cmd_i.close;
      end
      ST_LEN:    cur_byte = head_cmd_i.total_len;
      ST_CTRL:   cur_byte = cfg_i.control_byte;
      ST_INSTR:  cur_byte = head_cmd_i.instruction;
      ST_TAG_HI: cur_byte = head_cmd_i.tag[15:8];
      ST_TAG_LO: cur_byte = head_cmd_i.tag[7:0];
      ST_DLEN: begin
        cur_byte   = head_cmd_i.declared_len;
        final_step = !head_cmd_i.close;
      end
      ST_LRC:    cur_byte = lrc_q;
      ST_END: begin
        cur_byte   = cfg_i.end_byte;
        final_step = 1'b1;
      end
      default: begin
        cur_byte   = '0;
        final_step = 1'b1;
      end
    endcase

    lrc_d = lrc_q;
    if (emit) begin
      if (step_q == ST_FIRST && !head_cmd_i.is_payload) begin
        lrc_d = cur_byte;
      end else if (step_q == ST_END) begin
        lrc_d = '0;
      end else begin
        lrc_d = lrc_q ^ cur_byte;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_FIRST;
      lrc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      lrc_q  <= lrc_d;
      if (can_emit) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.out_byte  <= cur_byte;
      out_q.run_last  <= final_step;
      out_q.frame_end <= (step_q == ST_END);
    end
  end

endmodule

[hw/rtl/tlv_frame_builder_lrc.sv]
// Frame builder with XOR check byte. A start word queues a header of seven
// bytes (nine with check byte and end marker when the payload is empty);
// each payload word queues one byte, three on the last. The serializer
// sends one byte per cycle through a registered output while commands are
// queued and out_ready_i does not stall it; the input takes one word per
// cycle while the FifoDepth-entry command queue has room. Payload words
// with no open frame are dropped. Registers 0..2 hold start, control and
// end bytes; other indexes are ignored.
module tlv_frame_builder_lrc
  import tfb_pkg::*;
#(
  parameter int unsigned FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  tfb_in_t    in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output tfb_out_t   out_word_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  tfb_cfg_t cfg_q;
  logic     q_full, push, head_valid, pop;
  tfb_cmd_t push_cmd, head_cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte   <= 8'd2;
      cfg_q.control_byte <= 8'd0;
      cfg_q.end_byte     <= 8'd3;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_START:   cfg_q.start_byte   <= cfg_data_i;
        REG_CONTROL: cfg_q.control_byte <= cfg_data_i;
        REG_END:     cfg_q.end_byte     <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  tfb_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_word_i,
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  tfb_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (push),
    .push_cmd_i   (push_cmd),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  tfb_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_cmd_i   (head_cmd),
    .pop_o        (pop),
    .out_valid_o,
    .out_ready_i,
    .out_word_o
  );

endmodule

[hw/rtl/tfb_checker.sv]
module tfb_checker
  import tfb_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tfb_out_t out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("output word changed while stalled");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_end |-> out_word_o.run_last)
    else $error("end marker not flagged as last result");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind tlv_frame_builder_lrc tfb_checker u_tfb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
